// ----- hw/rtl/utf16_to_utf8_transcoder_assert.svh -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder assertion macros
// shared property forms for the transcoder checkers
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// same-cycle implication, off during reset
`define UTT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// next-cycle implication, off during reset
`define UTT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// next-cycle implication, also checked through reset
`define UTT_ASSERT_NXT_NR(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: reset check failed");

`endif

// ----- hw/rtl/utt_pkg.sv -----
// ----------------------------------------------------------------------------
// utt_pkg
// shared types, constants and the utf-8 encoder for the transcoder
// ----------------------------------------------------------------------------
package utt_pkg;

   localparam logic [1:0] CSR_SURROGATE_MODE = 2'd0;
   localparam logic [1:0] CSR_BYTE_LIMIT     = 2'd1;
   localparam logic [1:0] CSR_CHAR_LIMIT     = 2'd2;

   localparam logic [15:0] REPL_CHAR = 16'hFFFD;
   localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;

   localparam int JOB_MAX_BYTES   = 6;
   localparam int JOB_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [0:3][7:0] b;
      logic [2:0]      len;
   } utt_enc_type;

   typedef struct packed {
      logic [0:JOB_MAX_BYTES-1][7:0] bytes;
      logic [2:0]                    nbytes;
      logic                          done;
      logic [31:0]                   total;
      logic                          trunc;
   } utt_job_type;

   function automatic utt_enc_type utt_encode(input logic [20:0] cp);
      utt_enc_type e;
      e = '0;
      if (cp <= 21'h00007F) begin
         e.b[0] = cp[7:0];
         e.len  = 3'd1;
      end else if (cp <= 21'h0007FF) begin
         e.b[0] = {3'b110, cp[10:6]};
         e.b[1] = {2'b10, cp[5:0]};
         e.len  = 3'd2;
      end else if (cp <= 21'h00FFFF) begin
         e.b[0] = {4'b1110, cp[15:12]};
         e.b[1] = {2'b10, cp[11:6]};
         e.b[2] = {2'b10, cp[5:0]};
         e.len  = 3'd3;
      end else begin
         e.b[0] = {5'b11110, cp[20:18]};
         e.b[1] = {2'b10, cp[17:12]};
         e.b[2] = {2'b10, cp[11:6]};
         e.b[3] = {2'b10, cp[5:0]};
         e.len  = 3'd4;
      end
      return e;
   endfunction

endpackage

// ----- hw/rtl/utt_if.sv -----
// ----------------------------------------------------------------------------
// utt channel interfaces
// valid/ready channels for code units in and utf-8 words out
// ----------------------------------------------------------------------------
interface utt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        final_unit;

   modport source (output valid, output code_unit, output final_unit, input ready);
   modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface utt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        last_of_run;
   logic        done_res;
   logic [31:0] total_bytes;
   logic        truncated;

   modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                   output done_res, output total_bytes, output truncated, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
                   input done_res, input total_bytes, input truncated, output ready);
endinterface

// ----- hw/rtl/utf16_to_utf8_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a stream of utf-16 code units into utf-8 words, one byte per
// output word, with surrogate pairing and replacement of unpaired surrogates
// (surrogate mode clear), optional byte and code point limits and a closing
// status word per string. A unit is classified and encoded in the cycle it
// is accepted and placed in a two-entry job queue; the output stage then
// drains each job word by word. A unit that yields one word (plain ascii)
// sustains one unit per cycle while the output is ready; a unit that yields
// n words (up to seven: two code points plus the status word) holds the
// byte port for all n, and the queue absorbs this so input is still taken.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   utt_req_if.sink     req_chan,
   utt_rsp_if.source   rsp_chan
);
   import utt_pkg::*;

   logic        push, queue_full, job_valid, pop;
   utt_job_type push_job, head_job;

   utt_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_chan   (req_chan),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   utt_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .job_valid (job_valid),
      .head_job  (head_job)
   );

   utt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- hw/rtl/utt_job_fifo.sv -----
// ----------------------------------------------------------------------------
// utt_job_fifo
// short queue of encoded jobs between the front and back parts
// ----------------------------------------------------------------------------
module utt_job_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  utt_pkg::utt_job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               job_valid,
   output utt_pkg::utt_job_type head_job
);
   import utt_pkg::*;

   localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

   utt_job_type      entry_ff [JOB_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(JOB_QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign head_job  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && job_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hw/rtl/utt_front.sv -----
// ----------------------------------------------------------------------------
// utt_front
// takes code units, pairs surrogates, applies limits and builds byte jobs
// ----------------------------------------------------------------------------
module utt_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   utt_req_if.sink            req_chan,
   output logic               push,
   output utt_pkg::utt_job_type push_job,
   input  logic               queue_full
);
   import utt_pkg::*;

   localparam int W  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam int SW = W + 1;
   localparam logic [SW-1:0] CNT_MAX = {{(SW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

   logic                   mode_ff;
   logic [31:0]            blim_ff;
   logic [31:0]            clim_ff;
   logic                   pend_ff, pend_in;
   logic [9:0]             hbits_ff, hbits_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;
   logic [COUNT_WIDTH-1:0] chars_ff, chars_in;
   logic                   halt_ff, halt_in;

   logic [15:0]   u;
   logic          fin, is_high, is_low, ph, accept;
   logic [20:0]   cp1;
   logic [15:0]   cp2_val;
   logic          cp2_use, hold_high, alone_reach;
   utt_enc_type   enc1, enc2;
   logic [SW-1:0] b_ext, c_ext, blim_ext, clim_ext;
   logic [SW-1:0] len1_ext, len2_ext;
   logic [SW-1:0] sum1, sum2, sum12, sum_sat2, b_l2, c_inc, c_after1;
   logic          blim_on, clim_on;
   logic          fail1, emit1, try2, fail2, emit2;
   logic [2:0]    base2, len_tot;
   logic [1:0]    c_add;
   logic [SW-1:0] bsum, csum, bytes_sat;

   assign u        = req_chan.code_unit;
   assign fin      = req_chan.final_unit;
   assign is_high  = (u[15:10] == HIGH_SURR_TAG);
   assign is_low   = (u[15:10] == LOW_SURR_TAG);
   assign ph       = pend_ff && !halt_ff;
   assign accept   = req_chan.valid && !queue_full;
   assign req_chan.ready = !queue_full;

   // code point completed by a held high surrogate
   assign cp1 = (ph && is_low) ? (21'h010000 + {1'b0, hbits_ff, u[9:0]})
                               : {5'd0, REPL_CHAR};
   assign alone_reach = !halt_ff && !(ph && is_low);

   always_comb begin
      cp2_use   = 1'b1;
      cp2_val   = u;
      hold_high = 1'b0;
      if (mode_ff) begin
         cp2_val = u;
      end else if (is_low) begin
         cp2_val = REPL_CHAR;
      end else if (is_high) begin
         cp2_val = REPL_CHAR;
         if (!fin) begin
            cp2_use   = 1'b0;
            hold_high = 1'b1;
         end
      end
   end

   assign enc1 = utt_encode(cp1);
   assign enc2 = utt_encode({5'd0, cp2_val});

   assign b_ext    = {{(SW-COUNT_WIDTH){1'b0}}, bytes_ff};
   assign c_ext    = {{(SW-COUNT_WIDTH){1'b0}}, chars_ff};
   assign blim_ext = {{(SW-32){1'b0}}, blim_ff};
   assign clim_ext = {{(SW-32){1'b0}}, clim_ff};
   assign len1_ext = {{(SW-3){1'b0}}, enc1.len};
   assign len2_ext = {{(SW-3){1'b0}}, enc2.len};
   assign blim_on  = (blim_ff != '0);
   assign clim_on  = (clim_ff != '0);

   // limit checks for both code points in parallel
   assign sum1     = b_ext + len1_ext;
   assign sum2     = b_ext + len2_ext;
   assign sum12    = b_ext + len1_ext + len2_ext;
   assign sum_sat2 = CNT_MAX + len2_ext;
   assign c_inc    = c_ext + 1'b1;

   assign fail1 = ph && ((clim_on && (c_ext >= clim_ext)) || (blim_on && (sum1 > blim_ext)));
   assign emit1 = ph && !fail1;

   assign b_l2     = !emit1 ? sum2 : ((sum1 > CNT_MAX) ? sum_sat2 : sum12);
   assign c_after1 = !emit1 ? c_ext : ((c_inc > CNT_MAX) ? CNT_MAX : c_inc);

   assign try2  = alone_reach && cp2_use && !fail1;
   assign fail2 = (clim_on && (c_after1 >= clim_ext)) || (blim_on && (b_l2 > blim_ext));
   assign emit2 = try2 && !fail2;

   assign base2   = emit1 ? enc1.len : 3'd0;
   assign len_tot = base2 + (emit2 ? enc2.len : 3'd0);
   assign c_add   = {1'b0, emit1} + {1'b0, emit2};
   assign bsum    = b_ext + {{(SW-3){1'b0}}, len_tot};
   assign csum    = c_ext + {{(SW-2){1'b0}}, c_add};

   assign bytes_sat = (bsum > CNT_MAX) ? CNT_MAX : bsum;
   assign halt_in  = halt_ff || fail1 || (try2 && fail2);
   assign bytes_in = bytes_sat[COUNT_WIDTH-1:0];
   assign chars_in = (csum > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0] : csum[COUNT_WIDTH-1:0];
   assign pend_in  = alone_reach && !fail1 && hold_high;
   assign hbits_in = hold_high ? u[9:0] : hbits_ff;

   // pack first and second code point bytes back to back
   always_comb begin
      push_job = '0;
      for (int i = 0; i < JOB_MAX_BYTES; i++) begin
         for (int j = 0; j < 4; j++) begin
            if (emit2 && (j < int'(enc2.len)) && (i == int'(base2) + j)) begin
               push_job.bytes[i] = enc2.b[j];
            end
         end
         if (emit1 && (i < 4) && (i < int'(enc1.len))) begin
            push_job.bytes[i] = enc1.b[i];
         end
      end
      push_job.nbytes = len_tot;
      push_job.done   = fin;
      push_job.total  = bytes_sat[31:0];
      push_job.trunc  = halt_in;
   end

   assign push = accept && ((len_tot != '0) || fin);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         blim_ff <= '0;
         clim_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SURROGATE_MODE: mode_ff <= csr_wdata[0];
            CSR_BYTE_LIMIT:     blim_ff <= csr_wdata;
            CSR_CHAR_LIMIT:     clim_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         hbits_ff <= '0;
         bytes_ff <= '0;
         chars_ff <= '0;
         halt_ff  <= 1'b0;
      end else if (accept) begin
         if (fin) begin
            pend_ff  <= 1'b0;
            hbits_ff <= '0;
            bytes_ff <= '0;
            chars_ff <= '0;
            halt_ff  <= 1'b0;
         end else begin
            pend_ff  <= pend_in;
            hbits_ff <= hbits_in;
            bytes_ff <= bytes_in;
            chars_ff <= chars_in;
            halt_ff  <= halt_in;
         end
      end
   end

endmodule

// ----- hw/rtl/utt_back.sv -----
// ----------------------------------------------------------------------------
// utt_back
// walks each queued job and drives one output word per cycle while the output is ready
// ----------------------------------------------------------------------------
module utt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  utt_pkg::utt_job_type head_job,
   output logic               pop,
   utt_rsp_if.source          rsp_chan
);
   import utt_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        byte_valid_ff, last_ff, done_ff, trunc_ff;
   logic [31:0] total_ff;

   logic [2:0] n_items;
   logic       is_byte, is_last, load;
   logic [7:0] sel_byte;

   assign n_items = head_job.nbytes + {2'b00, head_job.done};
   assign is_byte = (pos_ff < head_job.nbytes);
   assign is_last = (pos_ff == n_items - 3'd1);
   assign load    = job_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pop     = load && is_last;

   always_comb begin
      sel_byte = '0;
      for (int i = 0; i < JOB_MAX_BYTES; i++) begin
         if (pos_ff == 3'(i)) begin
            sel_byte = head_job.bytes[i];
         end
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         pos_in       = is_last ? 3'd0 : pos_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff   <= is_byte ? sel_byte : 8'd0;
         byte_valid_ff <= is_byte;
         last_ff       <= is_last;
         done_ff       <= !is_byte;
         total_ff      <= is_byte ? 32'd0 : head_job.total;
         trunc_ff      <= is_byte ? 1'b0 : head_job.trunc;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.byte_valid  = byte_valid_ff;
   assign rsp_chan.last_of_run = last_ff;
   assign rsp_chan.done_res    = done_ff;
   assign rsp_chan.total_bytes = total_ff;
   assign rsp_chan.truncated   = trunc_ff;

endmodule

// ----- hw/rtl/utt_checker.sv -----
// ----------------------------------------------------------------------------
// utt_checker
// port-level checks on the transcoder output channel
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_assert.svh"

module utt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic        rsp_last_of_run,
   input logic        rsp_done_res,
   input logic [31:0] rsp_total_bytes,
   input logic        rsp_truncated
);

   // stalled word holds
   `UTT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_byte_valid) && $stable(rsp_done_res) && $stable(rsp_last_of_run) && $stable(rsp_total_bytes))

   // output stage is empty right after reset
   `UTT_ASSERT_NXT_NR(a_rsp_reset, clock, reset, !rsp_valid)

   // status word closes its run and carries no byte
   `UTT_ASSERT_IMP(a_done_shape, clock, reset, rsp_valid && rsp_done_res, rsp_last_of_run && !rsp_byte_valid && rsp_out_byte == 8'd0)

   // byte word carries no status
   `UTT_ASSERT_IMP(a_byte_shape, clock, reset, rsp_valid && !rsp_done_res, rsp_byte_valid && rsp_total_bytes == 32'd0 && !rsp_truncated)

endmodule

bind utf16_to_utf8_transcoder utt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_byte_valid  (rsp_chan.byte_valid),
   .rsp_last_of_run (rsp_chan.last_of_run),
   .rsp_done_res    (rsp_chan.done_res),
   .rsp_total_bytes (rsp_chan.total_bytes),
   .rsp_truncated   (rsp_chan.truncated)
);
